[sv/bif_pkg.sv]
// Shared types and constants for the bilateral image filter.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package bif_pkg;

    localparam int OP_W         = 2;
    localparam int PIX_W        = 8;
    localparam int IDX_W        = 8;
    localparam int WV_W         = 17;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int HGT_W        = 11;
    localparam int RADCFG_W     = 2;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int PIPE_DRAIN   = 4;
    localparam int DRAIN_W      = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PIXEL   = 2'd0,
        OP_RANGE   = 2'd1,
        OP_SPATIAL = 2'd2,
        OP_FLUSH   = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_TAPS,
        ST_DRAIN,
        ST_DIV_INIT,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd_centre;
        logic tap_step;
        logic div_init;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic tap_last;
        logic div_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

[sv/bilateral_image_filter_core.sv]
// Top level of the streaming bilateral filter: controller plus datapath.
// Depends on bif_pkg, bif_ctrl and bif_datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  in      | in_valid / in_ready  | operation, pixel_value, table_index, weight_value
//  out     | out_valid / out_ready| filtered_pixel, frame_end
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A request that yields no result leaves the controller idle. A request that yields a
// pixel takes one line store read per window tap, a four-stage weight pipeline, then a
// NUM_W-bit divider (NUM_W = 32 at R=3 with 16 fraction bits) giving one quotient bit a
// cycle. A result still waiting in the output register holds the controller, and so the
// input, until the receiver takes it; the next request is taken once it is loaded.
// No clearing pass after reset; tables and line store hold junk until written.
`default_nettype none
module bilateral_image_filter_core #(
    parameter int MAX_WIDTH        = 1024,
    parameter int MAX_RADIUS       = 3,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [bif_pkg::OP_W-1:0]         operation,
    input  wire  [bif_pkg::PIX_W-1:0]        pixel_value,
    input  wire  [bif_pkg::IDX_W-1:0]        table_index,
    input  wire  [bif_pkg::WV_W-1:0]         weight_value,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [bif_pkg::PIX_W-1:0]        filtered_pixel,
    output logic                             frame_end,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [bif_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [bif_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bif_pkg::*;

    cmd_t    cmd;
    status_t status;

    // writes must arrive only while idle (the block does not enforce this), so always take them
    assign cfg_ready = 1'b1;

    bif_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bif_datapath #(
        .MAX_WIDTH        (MAX_WIDTH),
        .MAX_RADIUS       (MAX_RADIUS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .operation      (operation),
        .pixel_value    (pixel_value),
        .table_index    (table_index),
        .weight_value   (weight_value),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_pixel (filtered_pixel),
        .frame_end      (frame_end)
    );

endmodule
`default_nettype wire

[sv/bif_ctrl.sv]
// Sequencer for the bilateral filter: accept, tap walk, drain, divide, hand-off.
// Depends on bif_pkg for state, command and status types.
`default_nettype none
module bif_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  bif_pkg::status_t status,
    output bif_pkg::cmd_t    cmd
);
    import bif_pkg::*;

    state_t               state_reg, state_next;
    logic [DRAIN_W-1:0]   drain_reg, drain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && status.emit)
                    state_next = ST_CENTRE;
            end
            ST_CENTRE:
            begin
                cmd.rd_centre = 1'b1;
                state_next    = ST_TAPS;
            end
            ST_TAPS:
            begin
                cmd.tap_step = 1'b1;
                if (status.tap_last)
                begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // let the weight pipeline empty into the accumulators
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_W'(PIPE_DRAIN - 1))
                    state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[sv/bif_datapath.sv]
// Datapath of the bilateral filter: config registers, frame counters, line store,
// weight tables, tap weight pipeline, accumulators and restoring divider. Uses bif_pkg.
`default_nettype none
module bif_datapath #(
    parameter int MAX_WIDTH        = 1024,
    parameter int MAX_RADIUS       = 3,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  bif_pkg::cmd_t                    cmd,
    output bif_pkg::status_t                 status,
    input  wire  [bif_pkg::OP_W-1:0]         operation,
    input  wire  [bif_pkg::PIX_W-1:0]        pixel_value,
    input  wire  [bif_pkg::IDX_W-1:0]        table_index,
    input  wire  [bif_pkg::WV_W-1:0]         weight_value,
    input  wire                              cfg_valid,
    input  wire  [bif_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [bif_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [bif_pkg::PIX_W-1:0]        filtered_pixel,
    output logic                             frame_end
);
    import bif_pkg::*;

    localparam int TAPS_MAX    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int STORE_DEPTH = (2 * MAX_RADIUS + 1) * (MAX_WIDTH + 1);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(MAX_WIDTH + 1);
    localparam int CW          = (COL_W > CFG_DATA_W) ? COL_W : CFG_DATA_W;
    localparam int ROW_W       = HGT_W;
    localparam int POS_W       = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 1);
    localparam int RAD_W       = $clog2(MAX_RADIUS + 1);
    localparam int OFS_W       = RAD_W + 1;
    localparam int WT_W        = WEIGHT_FRAC_BITS + 1;
    localparam int LD_W        = (WT_W > WV_W) ? WT_W : WV_W;
    localparam int PROD_W      = 2 * WT_W;
    localparam int DEN_W       = $clog2(TAPS_MAX) + WT_W;
    localparam int NUM_W       = DEN_W + PIX_W + 1;
    localparam int CNT_W       = $clog2(NUM_W);

    localparam logic [WT_W-1:0]   WEIGHT_ONE = WT_W'(1) << WEIGHT_FRAC_BITS;
    localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(1) << (WEIGHT_FRAC_BITS - 1);

    // configuration
    logic [CFG_DATA_W-1:0] width_reg, height_reg;
    logic [RADCFG_W-1:0]   radius_reg;
    logic                  cfg_we, cfg_restart;

    logic [COL_W-1:0]      eff_w;
    logic [ROW_W-1:0]      eff_h;
    logic [RAD_W-1:0]      eff_r;
    logic [CW-1:0]         w_ext;
    logic [RAD_W+1:0]      r_ext;
    logic [POS_W-1:0]      total, lag;
    logic [ADDR_W-1:0]     rw;

    // frame counters
    logic [COL_W-1:0]  in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [POS_W-1:0]  in_cnt_reg, in_cnt_next, out_pos_reg, out_pos_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next, out_addr_reg, out_addr_next;

    op_t   op;
    logic  done, pend, ready_pix, emit, pix_wr, frame_last;

    // latched output position
    logic [ROW_W-1:0]  p_row_reg;
    logic [COL_W-1:0]  p_col_reg;
    logic [ADDR_W-1:0] p_addr_reg;
    logic              fe_reg;

    // tap walk
    logic signed [OFS_W-1:0] dy_reg, dx_reg, r_s;
    logic [ADDR_W-1:0]       row_addr_reg, row_init, row_step, tap_addr, rd_addr;
    logic [ADDR_W:0]         row_sum, tap_sum;
    logic [OFS_W-1:0]        dx_mag, dy_mag;
    logic signed [ROW_W+1:0] rr;
    logic signed [COL_W+1:0] cc;
    logic                    in_window, ctap, rd_en;
    logic [3:0]              sidx;

    // memories and tables
    logic [PIX_W-1:0] line_store [STORE_DEPTH];
    logic [WT_W-1:0]  range_mem [256];
    logic [WT_W-1:0]  spatial_tab [16];
    logic [WT_W-1:0]  wv_sat;

    // weight pipeline
    logic [PIX_W-1:0]  store_q, centre_reg, diff, v2_reg, v3_reg, v4_reg;
    logic              s1_valid_reg, s1_cread_reg, s1_inside_reg, s1_ctap_reg;
    logic [3:0]        s1_sidx_reg;
    logic [WT_W-1:0]   range_q, sp2_reg, wt, wt4_reg;
    logic              s2_valid_reg, s2_ctap_reg, s3_valid_reg, s3_ctap_reg, s4_valid_reg;
    logic [PROD_W-1:0] prod3_reg;
    logic [PROD_W:0]   prod_round;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;

    // divider
    logic [NUM_W-1:0]  dvd_reg, quo_reg;
    logic [DEN_W:0]    rem_reg, rem_sh;
    logic [CNT_W-1:0]  div_cnt_reg;
    logic              qbit;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  filtered_reg;
    logic              frame_end_reg;

    // ---------------- configuration ----------------
    assign cfg_we      = cfg_valid;
    assign cfg_restart = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
                                    cfg_index == CFG_RADIUS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_DATA_W'(512);
            height_reg <= CFG_DATA_W'(512);
            radius_reg <= RADCFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_RADIUS: radius_reg <= cfg_data[RADCFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        w_ext = CW'(width_reg);
        if (w_ext == '0)
            eff_w = COL_W'(1);
        else if (w_ext > CW'(MAX_WIDTH))
            eff_w = COL_W'(MAX_WIDTH);
        else
            eff_w = COL_W'(w_ext);

        if (height_reg == '0)
            eff_h = ROW_W'(1);
        else if (height_reg > ROW_W'(HEIGHT_LIMIT))
            eff_h = ROW_W'(HEIGHT_LIMIT);
        else
            eff_h = height_reg;

        r_ext = (RAD_W + 2)'(radius_reg);
        if (r_ext > (RAD_W + 2)'(MAX_RADIUS))
            eff_r = RAD_W'(MAX_RADIUS);
        else
            eff_r = r_ext[RAD_W-1:0];
    end

    assign total = POS_W'(POS_W'(eff_w) * POS_W'(eff_h));
    assign rw    = ADDR_W'(ADDR_W'(eff_r) * ADDR_W'(eff_w));
    assign lag   = POS_W'(rw) + POS_W'(eff_r);

    // ---------------- item decode ----------------
    assign op        = op_t'(operation);
    assign done      = in_row_reg >= eff_h;
    assign pend      = out_pos_reg < total;
    assign ready_pix = ((POS_W + 1)'(out_pos_reg) + (POS_W + 1)'(lag)) <= (POS_W + 1)'(in_cnt_reg);
    assign frame_last = ((POS_W + 1)'(out_pos_reg) + (POS_W + 1)'(1)) >= (POS_W + 1)'(total);
    assign pix_wr    = cmd.accept && (op == OP_PIXEL) && !done;

    always_comb
    begin
        case (op) inside
            OP_RANGE, OP_SPATIAL: emit = 1'b0;
            default:
            begin
                // a pixel past the end of the frame acts as a flush
                if (op == OP_PIXEL && !done)
                    emit = ready_pix && pend;
                else
                    emit = done && pend;
            end
        endcase
    end

    // ---------------- frame counters ----------------
    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_cnt_next   = in_cnt_reg;
        wr_addr_next  = wr_addr_reg;
        out_pos_next  = out_pos_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_addr_next = out_addr_reg;

        if (pix_wr)
        begin
            in_cnt_next = in_cnt_reg + 1'b1;
            if (wr_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                wr_addr_next = '0;
            else
                wr_addr_next = wr_addr_reg + 1'b1;
            if (((COL_W + 1)'(in_col_reg) + (COL_W + 1)'(1)) >= (COL_W + 1)'(eff_w))
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end
            else
                in_col_next = in_col_reg + 1'b1;
        end

        if (cmd.accept && emit)
        begin
            if (frame_last)
            begin
                in_col_next   = '0;
                in_row_next   = '0;
                in_cnt_next   = '0;
                wr_addr_next  = '0;
                out_pos_next  = '0;
                out_col_next  = '0;
                out_row_next  = '0;
                out_addr_next = '0;
            end
            else
            begin
                out_pos_next = out_pos_reg + 1'b1;
                if (out_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                    out_addr_next = '0;
                else
                    out_addr_next = out_addr_reg + 1'b1;
                if (((COL_W + 1)'(out_col_reg) + (COL_W + 1)'(1)) >= (COL_W + 1)'(eff_w))
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                    out_col_next = out_col_reg + 1'b1;
            end
        end

        if (cfg_restart)
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_cnt_next   = '0;
            wr_addr_next  = '0;
            out_pos_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_cnt_reg   <= '0;
            wr_addr_reg  <= '0;
            out_pos_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_addr_reg <= '0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_cnt_reg   <= in_cnt_next;
            wr_addr_reg  <= wr_addr_next;
            out_pos_reg  <= out_pos_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_addr_reg <= out_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && emit)
        begin
            p_row_reg  <= out_row_reg;
            p_col_reg  <= out_col_reg;
            p_addr_reg <= out_addr_reg;
            fe_reg     <= frame_last;
        end
    end

    // ---------------- tap walk ----------------
    assign r_s = $signed({1'b0, eff_r});

    always_comb
    begin
        if (p_addr_reg >= rw)
            row_init = p_addr_reg - rw;
        else
            row_init = ADDR_W'((ADDR_W + 1)'(p_addr_reg) + (ADDR_W + 1)'(STORE_DEPTH)
                               - (ADDR_W + 1)'(rw));

        row_sum = (ADDR_W + 1)'(row_addr_reg) + (ADDR_W + 1)'(eff_w);
        if (row_sum >= (ADDR_W + 1)'(STORE_DEPTH))
            row_step = ADDR_W'(row_sum - (ADDR_W + 1)'(STORE_DEPTH));
        else
            row_step = ADDR_W'(row_sum);

        dx_mag = (dx_reg < 0) ? OFS_W'(-dx_reg) : OFS_W'(dx_reg);
        dy_mag = (dy_reg < 0) ? OFS_W'(-dy_reg) : OFS_W'(dy_reg);

        if (dx_reg < 0)
        begin
            if (row_addr_reg >= ADDR_W'(dx_mag))
                tap_sum = (ADDR_W + 1)'(row_addr_reg - ADDR_W'(dx_mag));
            else
                tap_sum = (ADDR_W + 1)'(row_addr_reg) + (ADDR_W + 1)'(STORE_DEPTH)
                          - (ADDR_W + 1)'(dx_mag);
        end
        else
        begin
            tap_sum = (ADDR_W + 1)'(row_addr_reg) + (ADDR_W + 1)'(dx_mag);
            if (tap_sum >= (ADDR_W + 1)'(STORE_DEPTH))
                tap_sum = tap_sum - (ADDR_W + 1)'(STORE_DEPTH);
        end
        tap_addr = ADDR_W'(tap_sum);

        rr = $signed({2'b00, p_row_reg}) + (ROW_W + 2)'(dy_reg);
        cc = $signed({2'b00, p_col_reg}) + (COL_W + 2)'(dx_reg);
        in_window = (rr >= 0) && (rr < $signed({2'b00, eff_h})) &&
                    (cc >= 0) && (cc < $signed({2'b00, eff_w}));
        ctap = (dy_reg == 0) && (dx_reg == 0);
        sidx = {dy_mag[1:0], dx_mag[1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_centre)
        begin
            dy_reg       <= -r_s;
            dx_reg       <= -r_s;
            row_addr_reg <= row_init;
        end
        else if (cmd.tap_step)
        begin
            if (dx_reg == r_s)
            begin
                dx_reg       <= -r_s;
                dy_reg       <= dy_reg + 1'b1;
                row_addr_reg <= row_step;
            end
            else
                dx_reg <= dx_reg + 1'b1;
        end
    end

    assign rd_en   = cmd.rd_centre || cmd.tap_step;
    assign rd_addr = cmd.rd_centre ? p_addr_reg : tap_addr;

    always_ff @(posedge clk)
    begin
        if (pix_wr)
            line_store[wr_addr_reg] <= pixel_value;
        if (rd_en)
            store_q <= line_store[rd_addr];
    end

    // ---------------- weight tables ----------------
    assign wv_sat = (LD_W'(weight_value) > LD_W'(WEIGHT_ONE)) ? WEIGHT_ONE
                                                             : WT_W'(weight_value);

    assign diff = (store_q > centre_reg) ? store_q - centre_reg : centre_reg - store_q;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && op == OP_RANGE)
            range_mem[table_index] <= wv_sat;
        range_q <= range_mem[diff];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && op == OP_SPATIAL && table_index < IDX_W'(16))
            spatial_tab[table_index[3:0]] <= wv_sat;
    end

    // ---------------- weight pipeline ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_cread_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.tap_step;
            s1_cread_reg <= cmd.rd_centre;
            s2_valid_reg <= s1_valid_reg && s1_inside_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    assign prod_round = (PROD_W + 1)'(prod3_reg) + ROUND_HALF;
    assign wt = s3_ctap_reg ? WEIGHT_ONE : WT_W'(prod_round >> WEIGHT_FRAC_BITS);

    always_ff @(posedge clk)
    begin
        s1_inside_reg <= in_window;
        s1_ctap_reg   <= ctap;
        s1_sidx_reg   <= sidx;
        if (s1_cread_reg)
            centre_reg <= store_q;
        sp2_reg     <= spatial_tab[s1_sidx_reg];
        v2_reg      <= store_q;
        s2_ctap_reg <= s1_ctap_reg;
        prod3_reg   <= PROD_W'(range_q) * PROD_W'(sp2_reg);
        v3_reg      <= v2_reg;
        s3_ctap_reg <= s2_ctap_reg;
        wt4_reg     <= wt;
        v4_reg      <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_centre)
        begin
            num_reg <= '0;
            den_reg <= '0;
        end
        else if (s4_valid_reg)
        begin
            num_reg <= num_reg + NUM_W'((WT_W + PIX_W)'(wt4_reg) * (WT_W + PIX_W)'(v4_reg));
            den_reg <= den_reg + DEN_W'(wt4_reg);
        end
    end

    // ---------------- divider, one quotient bit a cycle ----------------
    assign rem_sh = {rem_reg[DEN_W-1:0], dvd_reg[NUM_W-1]};
    assign qbit   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            dvd_reg     <= num_reg + NUM_W'(den_reg >> 1);
            rem_reg     <= '0;
            quo_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= qbit ? rem_sh - {1'b0, den_reg} : rem_sh;
            dvd_reg     <= dvd_reg << 1;
            quo_reg     <= {quo_reg[NUM_W-2:0], qbit};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            filtered_reg  <= (quo_reg > NUM_W'(255)) ? PIX_W'(255) : quo_reg[PIX_W-1:0];
            frame_end_reg <= fe_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_pixel = filtered_reg;
    assign frame_end      = frame_end_reg;

    assign status.emit     = emit;
    assign status.tap_last = (dx_reg == r_s) && (dy_reg == r_s);
    assign status.div_last = div_cnt_reg == CNT_W'(NUM_W - 1);
    assign status.out_free = !out_valid_reg || out_ready;

`ifndef SYNTHESIS
    a_den_has_centre: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_init |-> den_reg >= DEN_W'(WEIGHT_ONE))
        else $error("divisor lacks the centre weight");

    a_quotient_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> quo_reg <= NUM_W'(255))
        else $error("weighted mean above full scale");

    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load_out))
        else $error("result raised without a load");
`endif

endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking testbench for bilateral_image_filter_core.
// Depends on bif_pkg and the core; holds its own model of the filter and checks each output pixel.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bif_pkg::*;

    localparam int          MAX_W       = 1024;
    localparam int          MAX_R       = 3;
    localparam int          FRAC        = 16;
    localparam int          STORE       = (2 * MAX_R + 1) * (MAX_W + 1);
    localparam longint      ONE_Q       = 64'd1 << FRAC;
    localparam int          DRAIN_WAIT  = 120;
    localparam longint      CYCLE_LIMIT = 3000000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [OP_W-1:0]       operation;
    logic [PIX_W-1:0]      pixel_value;
    logic [IDX_W-1:0]      table_index;
    logic [WV_W-1:0]       weight_value;
    logic                  out_valid;
    logic                  out_ready;
    logic [PIX_W-1:0]      filtered_pixel;
    logic                  frame_end;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bilateral_image_filter_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .pixel_value    (pixel_value),
        .table_index    (table_index),
        .weight_value   (weight_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_pixel (filtered_pixel),
        .frame_end      (frame_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // filter model state
    logic [7:0]   line_mem [STORE];
    int unsigned  range_lut [256];
    int unsigned  spatial_lut [16];
    int unsigned  reg_w, reg_h, reg_r;
    int unsigned  in_col, in_row, out_pos;

    logic [7:0]   exp_pixel [$];
    logic         exp_end [$];

    int           tx_idle;
    int           rx_idle;
    int           hold_cycles;
    int           error_count;
    int           pixels_sent;
    longint       cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int unsigned eff_w();
        if (reg_w < 1) return 1;
        if (reg_w > MAX_W) return MAX_W;
        return reg_w;
    endfunction

    function automatic int unsigned eff_h();
        if (reg_h < 1) return 1;
        if (reg_h > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return reg_h;
    endfunction

    function automatic int unsigned eff_r();
        return (reg_r > MAX_R) ? MAX_R : reg_r;
    endfunction

    function automatic void restart_counters();
        in_col  = 0;
        in_row  = 0;
        out_pos = 0;
    endfunction

    function automatic void model_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_WIDTH:  reg_w = val;
            CFG_HEIGHT: reg_h = val;
            CFG_RADIUS: reg_r = val[1:0];
            default:    return;
        endcase
        restart_counters();
    endfunction

    function automatic logic [7:0] bilateral_at(int unsigned p);
        int          w, h, rad, row, col, dy, dx, rr, cc;
        int unsigned centre, v, diff;
        longint unsigned num, den, wt, q;
        w = eff_w();
        h = eff_h();
        rad = eff_r();
        row = p / w;
        col = p % w;
        centre = line_mem[p % STORE];
        num = 0;
        den = 0;
        for (dy = -rad; dy <= rad; dy++) begin
            for (dx = -rad; dx <= rad; dx++) begin
                rr = row + dy;
                cc = col + dx;
                if (rr < 0 || cc < 0 || rr >= h || cc >= w) continue;
                v = line_mem[(rr * w + cc) % STORE];
                if (dy == 0 && dx == 0) begin
                    wt = ONE_Q;
                end else begin
                    diff = (v > centre) ? v - centre : centre - v;
                    wt = longint'(spatial_lut[(((dy < 0 ? -dy : dy) & 3) << 2)
                                              | ((dx < 0 ? -dx : dx) & 3)])
                         * longint'(range_lut[diff & 255]);
                    wt = (wt + (ONE_Q >> 1)) >> FRAC;
                end
                num += wt * v;
                den += wt;
            end
        end
        q = (num + den / 2) / den;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic void push_output();
        int unsigned total;
        total = eff_w() * eff_h();
        exp_pixel.push_back(bilateral_at(out_pos));
        if (out_pos + 1 >= total) begin
            exp_end.push_back(1'b1);
            restart_counters();
        end else begin
            exp_end.push_back(1'b0);
            out_pos++;
        end
    endfunction

    function automatic void model_request(op_t op, logic [7:0] pix, logic [7:0] idx,
                                          logic [16:0] wv);
        int unsigned w, h, r, total, lag, k, wsat;
        bit          done;
        w = eff_w();
        h = eff_h();
        r = eff_r();
        total = w * h;
        lag = r * w + r;
        done = (in_row >= h);
        wsat = (wv > ONE_Q) ? ONE_Q : wv;
        if (op == OP_RANGE) begin
            range_lut[idx] = wsat;
            return;
        end
        if (op == OP_SPATIAL) begin
            if (idx < 16) spatial_lut[idx] = wsat;
            return;
        end
        if (op == OP_PIXEL && !done) begin
            k = in_row * w + in_col;
            line_mem[k % STORE] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (out_pos + lag <= k && out_pos < total) push_output();
            return;
        end
        if (done && out_pos < total) push_output();
    endfunction

    function automatic bit frame_draining();
        return in_row >= eff_h() && out_pos < eff_w() * eff_h();
    endfunction

    // one request on the input channel, with an optional gap before it
    task automatic send_request(op_t op, logic [7:0] pix, logic [7:0] idx, logic [16:0] wv);
        @(negedge clk);
        if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        operation    <= op;
        pixel_value  <= pix;
        table_index  <= idx;
        weight_value <= wv;
        in_valid     <= 1'b1;
        #1;
        while (!in_ready) begin
            @(negedge clk);
            #1;
        end
        model_request(op, pix, idx, wv);
        if (op == OP_PIXEL) pixels_sent++;
        @(posedge clk);
    endtask

    task automatic send_pixel(logic [7:0] pix);
        send_request(OP_PIXEL, pix, 8'($urandom), 17'($urandom));
    endtask

    task automatic send_flush();
        send_request(OP_FLUSH, 8'($urandom), 8'($urandom), 17'($urandom));
    endtask

    // stop offering and let the core go idle
    task automatic drain_outputs();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (exp_pixel.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        in_valid  <= 1'b0;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        #1;
        while (!cfg_ready) begin
            @(negedge clk);
            #1;
        end
        model_reg_write(idx, val);
        @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(int w, int h, int r);
        drain_outputs();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_RADIUS, r);
    endtask

    // finish the current frame with flush ticks
    task automatic flush_frame();
        while (frame_draining()) send_flush();
    endtask

    task automatic send_frame(int noise_pct);
        int n;
        n = eff_w() * eff_h();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                case ($urandom_range(2))
                    0: send_flush();
                    1: send_request(OP_RANGE, 8'($urandom), 8'($urandom), 17'($urandom));
                    default: send_request(OP_SPATIAL, 8'($urandom), 8'($urandom),
                                          17'($urandom));
                endcase
            end
            send_pixel(8'($urandom));
        end
        flush_frame();
    endtask

    // fill every table entry so that no unwritten weight is ever read
    task automatic test_table_load();
        send_request(OP_RANGE, 8'd0, 8'd0, 17'd65536);
        send_request(OP_RANGE, 8'd0, 8'd255, 17'h1FFFF);
        for (int i = 1; i < 255; i++)
            send_request(OP_RANGE, 8'($urandom), 8'(i), 17'($urandom_range(0, 70000)));
        for (int i = 0; i < 16; i++)
            send_request(OP_SPATIAL, 8'($urandom), 8'(i), 17'($urandom_range(0, 70000)));
        send_request(OP_SPATIAL, 8'd0, 8'd0, 17'h10001);
        send_request(OP_SPATIAL, 8'd0, 8'd16, 17'd0);
        send_request(OP_SPATIAL, 8'd0, 8'd255, 17'd0);
        send_request(OP_RANGE, 8'd0, 8'd128, 17'd0);
    endtask

    task automatic test_directed();
        set_frame(3, 3, 1);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_flush();                          // early flush: no effect
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd128);
        send_pixel(8'd127);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd1);
        send_pixel(8'd77);                     // extra pixel: acts as a flush
        flush_frame();
        send_flush();                          // idle flush once the frame has restarted
        // radius 0 and a single pixel frame via clamped width and height
        set_frame(0, 0, 0);
        send_pixel(8'd200);
        send_flush();
        write_reg(CFG_UNUSED, 11'h7FF);
        set_frame(2, 2, 3);
        send_frame(0);
    endtask

    // clamped width and height: run the head of each frame, then restart it
    task automatic test_large_frames();
        set_frame(11'h7FF, 11'h7FF, 0);
        repeat (24) send_pixel(8'($urandom));
        set_frame(1, 11'h7FF, 1);
        repeat (30) send_pixel(8'($urandom));
    endtask

    task automatic test_hold_off();
        set_frame(6, 5, 1);
        hold_cycles = 2000;
        send_frame(0);
    endtask

    task automatic test_pause();
        set_frame(5, 4, 2);
        for (int i = 0; i < 12; i++) send_pixel(8'($urandom));
        drain_outputs();                       // hold the sender until nothing is pending
        for (int i = 0; i < 8; i++) send_pixel(8'($urandom));
        flush_frame();
    endtask

    task automatic test_random(int tx_pct, int rx_pct, int quota);
        int target;
        tx_idle = tx_pct;
        rx_idle = rx_pct;
        target = pixels_sent + quota;
        while (pixels_sent < target) begin
            set_frame($urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(0, 3));
            if ($urandom_range(9) == 0) begin
                // abandon a frame midway
                repeat ($urandom_range(1, 8)) send_pixel(8'($urandom));
            end else begin
                send_frame(10);
            end
        end
    endtask

    // receiver: random stalls and the long hold-off
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            out_ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (exp_pixel.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected output pixel %0d frame_end %0b",
                             filtered_pixel, frame_end);
            end else begin
                if (filtered_pixel !== exp_pixel[0] || frame_end !== exp_end[0]) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected pixel %0d end %0b, got pixel %0d end %0b",
                                 exp_pixel[0], exp_end[0], filtered_pixel, frame_end);
                end
                void'(exp_pixel.pop_front());
                void'(exp_end.pop_front());
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = OP_PIXEL;
        pixel_value  = '0;
        table_index  = '0;
        weight_value = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_WIDTH;
        cfg_data     = '0;
        out_ready    = 1'b0;
        tx_idle      = 0;
        rx_idle      = 0;
        hold_cycles  = 0;
        error_count  = 0;
        pixels_sent  = 0;
        cycle_count  = 0;
        reg_w        = 512;
        reg_h        = 512;
        reg_r        = 1;
        restart_counters();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_table_load();
        test_directed();
        test_hold_off();
        test_pause();
        test_random(15, 81, 80);
        test_random(81, 15, 80);
        test_random(0, 0, 80);
        test_large_frames();

        drain_outputs();
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
sv/bif_pkg.sv
sv/bif_ctrl.sv
sv/bif_datapath.sv
sv/bilateral_image_filter_core.sv
test/tb.sv
